// ===== sv/rse_pkg.sv =====
`timescale 1ns / 1ps

package rse_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int FRAC_BITS   = 16;
  localparam int VAL_W       = 48;
  localparam int OPND_W      = 32;
  localparam int HALF_W      = VAL_W / 2;
  localparam int MAG_W       = 2 * VAL_W;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int DIV_W       = VAL_W + FRAC_BITS;
  localparam int DCNT_W      = $clog2(DIV_W);
  localparam int MUL_STEPS   = 4;

  typedef enum logic [2:0] {
    OP_NUM     = 3'd0,
    OP_ADD     = 3'd1,
    OP_SUB     = 3'd2,
    OP_DIV     = 3'd3,
    OP_MUL     = 3'd4,
    OP_END     = 3'd5,
    OP_INVALID = 3'd6
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BAD     = 3'd1,
    ST_DEPTH   = 3'd2,
    ST_DIVZERO = 3'd3,
    ST_FULL    = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_RD_R,
    S_RD_L,
    S_CAP_L,
    S_START,
    S_EXEC,
    S_WB,
    S_RD_BASE,
    S_EMIT
  } state_e;

  typedef enum logic [1:0] {
    RD_TOP,
    RD_NEXT,
    RD_BOTTOM
  } rd_sel_e;

  typedef struct packed {
    logic    load_in;
    logic    push;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    cap_r;
    logic    cap_l;
    logic    op_start;
    logic    wb;
    logic    cnt_clr;
    logic    sticky_clr;
    logic    discard_set;
    logic    discard_clr;
    logic    emit;
    logic    emit_value;
    status_e emit_code;
  } cmd_t;

  typedef struct packed {
    opcode_e opcode;
    logic    discarding;
    logic    full;
    logic    lt2;
    logic    is1;
    logic    r_zero;
    logic    op_done;
    logic    out_free;
  } stat_t;

  typedef struct packed {
    logic [VAL_W-1:0] val;
    logic             sat;
  } sat_res_t;

  localparam logic [MAG_W-1:0] MAG_NEG = MAG_W'(1) << (VAL_W - 1);
  localparam logic [MAG_W-1:0] MAG_POS = MAG_NEG - MAG_W'(1);

  // clamp a sign/magnitude value into the signed result range
  function automatic sat_res_t sat_mag(input logic neg, input logic ovf,
                                       input logic [MAG_W-1:0] mag);
    sat_res_t res;
    if (neg) begin
      if (ovf || mag > MAG_NEG) begin
        res.val = MAG_NEG[VAL_W-1:0];
        res.sat = 1'b1;
      end else begin
        res.val = VAL_W'(-mag[VAL_W-1:0]);
        res.sat = 1'b0;
      end
    end else begin
      if (ovf || mag > MAG_POS) begin
        res.val = MAG_POS[VAL_W-1:0];
        res.sat = 1'b1;
      end else begin
        res.val = mag[VAL_W-1:0];
        res.sat = 1'b0;
      end
    end
    return res;
  endfunction

endpackage

// ===== sv/rse_arith.sv =====
`timescale 1ns / 1ps

module rse_arith (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  rse_pkg::opcode_e            op_i,
  input  logic [rse_pkg::VAL_W-1:0]   l_i,
  input  logic [rse_pkg::VAL_W-1:0]   r_i,
  output logic                        done_o,
  output logic [rse_pkg::VAL_W-1:0]   res_o,
  output logic                        sat_o
);

  logic                              busy_q;
  logic                              done_q;
  logic [rse_pkg::DCNT_W-1:0]        cnt_q;
  rse_pkg::opcode_e                  kind_q;
  logic                              neg_q;
  logic [rse_pkg::VAL_W-1:0]         ma_q, mb_q;
  logic [rse_pkg::VAL_W:0]           sum_q;
  logic [rse_pkg::VAL_W-1:0]         pp_q;
  logic [1:0]                        sh_q;
  logic [rse_pkg::MAG_W-1:0]         acc_q;
  logic [rse_pkg::VAL_W-1:0]         rem_q;
  logic [rse_pkg::VAL_W:0]           quo_q;
  logic                              ovf_q;
  logic [rse_pkg::DIV_W-1:0]         num_q;

  logic [rse_pkg::VAL_W-1:0]         ma_s, mb_s;
  logic [rse_pkg::HALF_W-1:0]        a_part, b_part;
  logic [rse_pkg::MAG_W-1:0]         pp_sh;
  logic [rse_pkg::VAL_W:0]           trial;
  logic                              ge;
  logic [rse_pkg::VAL_W:0]           diff;
  rse_pkg::sat_res_t                 res;

  assign ma_s = l_i[rse_pkg::VAL_W-1] ? -l_i : l_i;
  assign mb_s = r_i[rse_pkg::VAL_W-1] ? -r_i : r_i;

  // partial products: lo*lo, lo*hi, hi*lo, hi*hi
  assign a_part = cnt_q[1] ? ma_q[rse_pkg::VAL_W-1:rse_pkg::HALF_W]
                           : ma_q[rse_pkg::HALF_W-1:0];
  assign b_part = cnt_q[0] ? mb_q[rse_pkg::VAL_W-1:rse_pkg::HALF_W]
                           : mb_q[rse_pkg::HALF_W-1:0];

  always_comb begin
    case (sh_q)
      2'd0:    pp_sh = rse_pkg::MAG_W'(pp_q);
      2'd1:    pp_sh = rse_pkg::MAG_W'(pp_q) << rse_pkg::HALF_W;
      default: pp_sh = rse_pkg::MAG_W'(pp_q) << rse_pkg::VAL_W;
    endcase
  end

  // restoring divide step, remainder stays below the divisor
  assign trial = {rem_q, num_q[rse_pkg::DIV_W-1]};
  assign ge    = trial >= {1'b0, mb_q};
  assign diff  = trial - {1'b0, mb_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + rse_pkg::DCNT_W'(1);
        case (kind_q) inside
          rse_pkg::OP_MUL: begin
            if (cnt_q == rse_pkg::DCNT_W'(rse_pkg::MUL_STEPS)) begin
              busy_q <= 1'b0;
              done_q <= 1'b1;
            end
          end
          rse_pkg::OP_DIV: begin
            if (cnt_q == rse_pkg::DCNT_W'(rse_pkg::DIV_W - 1)) begin
              busy_q <= 1'b0;
              done_q <= 1'b1;
            end
          end
          default: begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      kind_q <= op_i;
      neg_q  <= l_i[rse_pkg::VAL_W-1] ^ r_i[rse_pkg::VAL_W-1];
      ma_q   <= ma_s;
      mb_q   <= mb_s;
      if (op_i == rse_pkg::OP_SUB) begin
        sum_q <= {l_i[rse_pkg::VAL_W-1], l_i} - {r_i[rse_pkg::VAL_W-1], r_i};
      end else begin
        sum_q <= {l_i[rse_pkg::VAL_W-1], l_i} + {r_i[rse_pkg::VAL_W-1], r_i};
      end
      acc_q <= '0;
      rem_q <= '0;
      quo_q <= '0;
      ovf_q <= 1'b0;
      num_q <= {ma_s, {rse_pkg::FRAC_BITS{1'b0}}};
    end else if (busy_q) begin
      if (kind_q == rse_pkg::OP_MUL) begin
        if (cnt_q < rse_pkg::DCNT_W'(rse_pkg::MUL_STEPS)) begin
          pp_q <= rse_pkg::VAL_W'(a_part) * rse_pkg::VAL_W'(b_part);
          sh_q <= 2'(cnt_q[1]) + 2'(cnt_q[0]);
        end
        if (cnt_q != '0) begin
          acc_q <= acc_q + pp_sh;
        end
      end else if (kind_q == rse_pkg::OP_DIV) begin
        rem_q <= ge ? diff[rse_pkg::VAL_W-1:0] : trial[rse_pkg::VAL_W-1:0];
        quo_q <= {quo_q[rse_pkg::VAL_W-1:0], ge};
        ovf_q <= ovf_q | quo_q[rse_pkg::VAL_W];
        num_q <= num_q << 1;
      end
    end
  end

  always_comb begin
    case (kind_q) inside
      rse_pkg::OP_ADD, rse_pkg::OP_SUB: begin
        if (sum_q[rse_pkg::VAL_W] != sum_q[rse_pkg::VAL_W-1]) begin
          res.val = sum_q[rse_pkg::VAL_W] ? rse_pkg::MAG_NEG[rse_pkg::VAL_W-1:0]
                                          : rse_pkg::MAG_POS[rse_pkg::VAL_W-1:0];
          res.sat = 1'b1;
        end else begin
          res.val = sum_q[rse_pkg::VAL_W-1:0];
          res.sat = 1'b0;
        end
      end
      rse_pkg::OP_MUL: res = rse_pkg::sat_mag(neg_q, 1'b0, acc_q >> rse_pkg::FRAC_BITS);
      default:         res = rse_pkg::sat_mag(neg_q, ovf_q, rse_pkg::MAG_W'(quo_q));
    endcase
  end

  assign done_o = done_q;
  assign res_o  = res.val;
  assign sat_o  = res.sat;

endmodule

// ===== sv/rse_datapath.sv =====
`timescale 1ns / 1ps

module rse_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rse_pkg::cmd_t                 cmd_i,
  output rse_pkg::stat_t                stat_o,
  input  logic [2:0]                    opcode_i,
  input  logic signed [rse_pkg::OPND_W-1:0] operand_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [rse_pkg::VAL_W-1:0] result_value_o,
  output logic [2:0]                    status_o,
  output logic                          saturated_o
);

  logic [rse_pkg::VAL_W-1:0]          mem [rse_pkg::STACK_DEPTH];
  logic [rse_pkg::VAL_W-1:0]          rd_q, r_q, l_q;
  logic [rse_pkg::CNT_W-1:0]          cnt_q;
  logic                               discard_q;
  logic                               sticky_q;
  rse_pkg::opcode_e                   op_q;
  logic signed [rse_pkg::OPND_W-1:0]  operand_q;
  logic                               out_valid_q;
  logic [rse_pkg::VAL_W-1:0]          out_value_q;
  rse_pkg::status_e                   out_status_q;
  logic                               out_sat_q;

  logic [rse_pkg::CNT_W-1:0]          cnt_m1, cnt_m2;
  logic [rse_pkg::ADDR_W-1:0]         rd_addr;
  logic signed [rse_pkg::MAG_W-1:0]   conv_ext;
  logic [rse_pkg::MAG_W-1:0]          conv_mag;
  rse_pkg::sat_res_t                  conv;
  logic                               ar_done;
  logic [rse_pkg::VAL_W-1:0]          ar_res;
  logic                               ar_sat;

  assign cnt_m1 = cnt_q - rse_pkg::CNT_W'(1);
  assign cnt_m2 = cnt_q - rse_pkg::CNT_W'(2);

  always_comb begin
    unique case (cmd_i.rd_sel)
      rse_pkg::RD_TOP:  rd_addr = cnt_m1[rse_pkg::ADDR_W-1:0];
      rse_pkg::RD_NEXT: rd_addr = cnt_m2[rse_pkg::ADDR_W-1:0];
      default:          rd_addr = '0;
    endcase
  end

  // integer to fixed point
  assign conv_ext = rse_pkg::MAG_W'(operand_q) <<< rse_pkg::FRAC_BITS;
  assign conv_mag = operand_q[rse_pkg::OPND_W-1] ? -conv_ext : conv_ext;
  assign conv     = rse_pkg::sat_mag(operand_q[rse_pkg::OPND_W-1], 1'b0, conv_mag);

  rse_arith u_arith (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.op_start),
    .op_i    (op_q),
    .l_i     (l_q),
    .r_i     (r_q),
    .done_o  (ar_done),
    .res_o   (ar_res),
    .sat_o   (ar_sat)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[cnt_q[rse_pkg::ADDR_W-1:0]] <= conv.val;
    end else if (cmd_i.wb) begin
      mem[cnt_m2[rse_pkg::ADDR_W-1:0]] <= ar_res;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q      <= rse_pkg::opcode_e'(opcode_i);
      operand_q <= operand_value_i;
    end
    if (cmd_i.cap_r) begin
      r_q <= rd_q;
    end
    if (cmd_i.cap_l) begin
      l_q <= rd_q;
    end
    if (cmd_i.emit) begin
      out_value_q  <= cmd_i.emit_value ? rd_q : '0;
      out_status_q <= cmd_i.emit_code;
      out_sat_q    <= sticky_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      discard_q   <= 1'b0;
      sticky_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.push) begin
        cnt_q <= cnt_q + rse_pkg::CNT_W'(1);
      end else if (cmd_i.wb) begin
        cnt_q <= cnt_m1;
      end

      if (cmd_i.sticky_clr) begin
        sticky_q <= 1'b0;
      end else if ((cmd_i.wb && ar_sat) || (cmd_i.push && conv.sat)) begin
        sticky_q <= 1'b1;
      end

      if (cmd_i.discard_set) begin
        discard_q <= 1'b1;
      end else if (cmd_i.discard_clr) begin
        discard_q <= 1'b0;
      end

      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.opcode     = op_q;
  assign stat_o.discarding = discard_q;
  assign stat_o.full       = cnt_q >= rse_pkg::CNT_W'(rse_pkg::STACK_DEPTH);
  assign stat_o.lt2        = cnt_q < rse_pkg::CNT_W'(2);
  assign stat_o.is1        = cnt_q == rse_pkg::CNT_W'(1);
  assign stat_o.r_zero     = r_q == '0;
  assign stat_o.op_done    = ar_done;
  assign stat_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_value_q;
  assign status_o       = out_status_q;
  assign saturated_o    = out_sat_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= rse_pkg::CNT_W'(rse_pkg::STACK_DEPTH))
    else $error("stack count above depth");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> cnt_q < rse_pkg::CNT_W'(rse_pkg::STACK_DEPTH))
    else $error("push into full stack");

  a_wb_operands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wb |-> cnt_q >= rse_pkg::CNT_W'(2))
    else $error("writeback without two operands");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || !out_stall_i))
    else $error("result overwritten before transfer");

endmodule

// ===== sv/rse_ctrl.sv =====
`timescale 1ns / 1ps

module rse_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  rse_pkg::stat_t  stat_i,
  output rse_pkg::cmd_t   cmd_o
);

  rse_pkg::state_e  state_q, state_d;
  rse_pkg::status_e code_q, code_d;
  logic             fail_q, fail_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rse_pkg::S_IDLE;
      code_q  <= rse_pkg::ST_OK;
      fail_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
      fail_q  <= fail_d;
    end
  end

  always_comb begin
    state_d = state_q;
    code_d  = code_q;
    fail_d  = fail_q;
    unique case (state_q)
      rse_pkg::S_IDLE: begin
        if (in_valid_i) state_d = rse_pkg::S_DECODE;
      end
      rse_pkg::S_DECODE: begin
        state_d = rse_pkg::S_IDLE;
        if (!stat_i.discarding) begin
          case (stat_i.opcode) inside
            rse_pkg::OP_NUM: begin
              if (stat_i.full) begin
                code_d  = rse_pkg::ST_FULL;
                fail_d  = 1'b1;
                state_d = rse_pkg::S_EMIT;
              end
            end
            rse_pkg::OP_ADD, rse_pkg::OP_SUB, rse_pkg::OP_DIV, rse_pkg::OP_MUL: begin
              if (stat_i.lt2) begin
                code_d  = rse_pkg::ST_BAD;
                fail_d  = 1'b1;
                state_d = rse_pkg::S_EMIT;
              end else begin
                state_d = rse_pkg::S_RD_R;
              end
            end
            rse_pkg::OP_END: begin
              fail_d = 1'b0;
              if (stat_i.is1) begin
                code_d  = rse_pkg::ST_OK;
                state_d = rse_pkg::S_RD_BASE;
              end else begin
                code_d  = rse_pkg::ST_DEPTH;
                state_d = rse_pkg::S_EMIT;
              end
            end
            default: begin
              code_d  = rse_pkg::ST_BAD;
              fail_d  = 1'b1;
              state_d = rse_pkg::S_EMIT;
            end
          endcase
        end
      end
      rse_pkg::S_RD_R:  state_d = rse_pkg::S_RD_L;
      rse_pkg::S_RD_L:  state_d = rse_pkg::S_CAP_L;
      rse_pkg::S_CAP_L: begin
        if (stat_i.opcode == rse_pkg::OP_DIV && stat_i.r_zero) begin
          code_d  = rse_pkg::ST_DIVZERO;
          fail_d  = 1'b1;
          state_d = rse_pkg::S_EMIT;
        end else begin
          state_d = rse_pkg::S_START;
        end
      end
      rse_pkg::S_START:   state_d = rse_pkg::S_EXEC;
      rse_pkg::S_EXEC: begin
        if (stat_i.op_done) state_d = rse_pkg::S_WB;
      end
      rse_pkg::S_WB:      state_d = rse_pkg::S_IDLE;
      rse_pkg::S_RD_BASE: state_d = rse_pkg::S_EMIT;
      rse_pkg::S_EMIT: begin
        if (stat_i.out_free) state_d = rse_pkg::S_IDLE;
      end
      default: state_d = rse_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.rd_sel    = rse_pkg::RD_TOP;
    cmd_o.emit_code = code_q;
    in_stall_o      = state_q != rse_pkg::S_IDLE;
    unique case (state_q)
      rse_pkg::S_IDLE: begin
        cmd_o.load_in = in_valid_i;
      end
      rse_pkg::S_DECODE: begin
        if (stat_i.discarding) begin
          if (stat_i.opcode == rse_pkg::OP_END) begin
            cmd_o.cnt_clr     = 1'b1;
            cmd_o.sticky_clr  = 1'b1;
            cmd_o.discard_clr = 1'b1;
          end
        end else if (stat_i.opcode == rse_pkg::OP_NUM && !stat_i.full) begin
          cmd_o.push = 1'b1;
        end
      end
      rse_pkg::S_RD_R: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = rse_pkg::RD_TOP;
      end
      rse_pkg::S_RD_L: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = rse_pkg::RD_NEXT;
        cmd_o.cap_r  = 1'b1;
      end
      rse_pkg::S_CAP_L: begin
        cmd_o.cap_l = 1'b1;
      end
      rse_pkg::S_START: begin
        cmd_o.op_start = 1'b1;
      end
      rse_pkg::S_EXEC: begin
      end
      rse_pkg::S_WB: begin
        cmd_o.wb = 1'b1;
      end
      rse_pkg::S_RD_BASE: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = rse_pkg::RD_BOTTOM;
      end
      rse_pkg::S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_value  = code_q == rse_pkg::ST_OK;
          cmd_o.cnt_clr     = 1'b1;
          cmd_o.sticky_clr  = 1'b1;
          cmd_o.discard_set = fail_q;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== sv/rpn_stack_evaluator_unit.sv =====
`timescale 1ns / 1ps

// Reverse Polish evaluator. Tokens arrive on the input channel
// (in_valid_i / in_stall_o, opcode_i, operand_value_i); a token is taken
// when valid is high and stall is low. Numbers push a Q32.16 value onto a
// 16-entry stack, operators combine the top two, an end token returns the
// final value. Results leave on out_valid_o / out_stall_i with
// result_value_o, status_o and saturated_o; only end tokens and errors
// produce a result.
// A multiply forms four 24x24 partial products and accumulates them; a
// divide runs the restoring divider, which yields one quotient bit per
// cycle. Stack reads go through a registered single read port, so the
// operands are fetched in the RD_R, RD_L and CAP_L states. One token is
// in work at a time; in_stall_o is high until it ends. A result is held
// in the output register until transferred; the next token is taken
// meanwhile and only a token that must produce a result waits for the
// register to free up.
// Reset empties the stack and clears the error and saturation flags;
// stack contents need no clearing.
module rpn_stack_evaluator_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [2:0]                          opcode_i,
  input  logic signed [rse_pkg::OPND_W-1:0]   operand_value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [rse_pkg::VAL_W-1:0]    result_value_o,
  output logic [2:0]                          status_o,
  output logic                                saturated_o
);

  rse_pkg::cmd_t  cmd;
  rse_pkg::stat_t stat;

  rse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rse_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .opcode_i        (opcode_i),
    .operand_value_i (operand_value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .result_value_o  (result_value_o),
    .status_o        (status_o),
    .saturated_o     (saturated_o)
  );

endmodule
